FILE: hdl/kfli_pkg.sv
package kfli_pkg;

   localparam int MAX_KEYS   = 64;
   localparam int COMPONENTS = 5;
   localparam int FRAC_BITS  = 16;

   localparam int NUM_FIELDS = 5;
   localparam int VAL_W      = 32;
   localparam int TICK_W     = 24;
   localparam int STEP_W     = 16;
   localparam int KEYCNT_W   = 7;
   localparam int KEYIDX_W   = 6;
   localparam int KEY_W      = $clog2(MAX_KEYS);
   localparam int CNT_W      = (KEYCNT_W > $clog2(MAX_KEYS + 1)) ? KEYCNT_W
                                                                 : $clog2(MAX_KEYS + 1);
   localparam int DIV_W      = TICK_W + FRAC_BITS;
   localparam int PROD_W     = VAL_W + FRAC_BITS + 2;

   localparam int ST_DIV_END = DIV_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT  = 1'd1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INTERP = 2'd0,
      STATUS_HELD   = 2'd1,
      STATUS_EMPTY  = 2'd2
   } status_type;

   typedef struct packed {
      logic                    command;
      logic [KEYIDX_W-1:0]     key_index;
      logic [TICK_W-1:0]       tick;
      logic signed [VAL_W-1:0] value_a;
      logic signed [VAL_W-1:0] value_b;
      logic signed [VAL_W-1:0] value_c;
      logic signed [VAL_W-1:0] value_d;
      logic signed [VAL_W-1:0] value_e;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] result_a;
      logic signed [VAL_W-1:0] result_b;
      logic signed [VAL_W-1:0] result_c;
      logic signed [VAL_W-1:0] result_d;
      logic signed [VAL_W-1:0] result_e;
      status_type              status;
   } rsp_type;

   typedef logic [COMPONENTS-1:0][VAL_W-1:0] row_type;

   typedef struct packed {
      logic [STEP_W-1:0] rem;
      logic [DIV_W-1:0]  dq;
   } div_state_type;

   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [STEP_W-1:0] d);
      logic [STEP_W:0] shifted;
      logic [STEP_W:0] diff;
      div_state_type   n;
      shifted = {s.rem, s.dq[DIV_W-1]};
      diff    = shifted - {1'b0, d};
      if (!diff[STEP_W]) begin
         n.rem = diff[STEP_W-1:0];
         n.dq  = {s.dq[DIV_W-2:0], 1'b1};
      end else begin
         n.rem = shifted[STEP_W-1:0];
         n.dq  = {s.dq[DIV_W-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

FILE: hdl/keyframe_linear_interpolator_unit.sv
// A query result passes the divider, table read, product and output registers to rsp_valid.
// Throughput: one item per cycle while the skid register is empty, set by the 40-stage
// restoring divider pipeline yielding segment and fraction, then the table read and lerp.
// A write item updates the keyframe table in order and gives no result.
// Reset clears valids and key count, sets step_ticks to 1; the table is undefined until written.
module keyframe_linear_interpolator_unit import kfli_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [STEP_W-1:0]   step_ticks_ff;
   logic [KEYCNT_W-1:0] key_count_ff;
   logic [STEP_W-1:0]   steps;
   logic [CNT_W-1:0]    count;

   logic                en;
   logic [ST_DIV_END:0] valid_ff;
   req_type             item_ff [0:ST_DIV_END];
   div_state_type       div_ff  [0:ST_DIV_END];

   row_type             keyframe_mem [0:MAX_KEYS-1];
   row_type             wr_row;
   logic                wr_en;
   logic [KEY_W-1:0]    wr_addr;
   logic [KEY_W-1:0]    addr_a;
   logic [KEY_W-1:0]    addr_b;
   logic [TICK_W-1:0]   seg;
   logic [TICK_W:0]     seg_next;
   logic                interp;
   status_type          status_in;
   logic [FRAC_BITS-1:0] frac_in;

   logic                mem_valid_ff;
   status_type          mem_status_ff;
   logic [FRAC_BITS-1:0] mem_frac_ff;
   row_type             rd_a_ff;
   row_type             rd_b_ff;

   logic                mul_valid_ff;
   status_type          mul_status_ff;
   row_type             mul_base_ff;
   logic signed [PROD_W-1:0] mul_prod_ff [0:COMPONENTS-1];

   logic [NUM_FIELDS-1:0][VAL_W-1:0] res_fields;
   rsp_type             pipe_res;
   logic                skid_valid_ff;
   rsp_type             skid_ff;
   logic [NUM_FIELDS-1:0][VAL_W-1:0] in_fields;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ticks_ff <= STEP_W'(1);
         key_count_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_TICKS: step_ticks_ff <= csr_write_data[STEP_W-1:0];
            CSR_KEY_COUNT:  key_count_ff  <= csr_write_data[KEYCNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign steps = (step_ticks_ff == '0) ? STEP_W'(1) : step_ticks_ff;
   assign count = (CNT_W'(key_count_ff) > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                            : CNT_W'(key_count_ff);

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ST_DIV_END-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0]    <= req_payload;
         div_ff[0].rem <= '0;
         div_ff[0].dq  <= {req_payload.tick, {FRAC_BITS{1'b0}}};
         for (int k = 1; k <= ST_DIV_END; k++) begin
            item_ff[k] <= item_ff[k-1];
            div_ff[k]  <= div_step(div_ff[k-1], steps);
         end
      end
   end

   assign in_fields = {item_ff[ST_DIV_END].value_e, item_ff[ST_DIV_END].value_d,
                       item_ff[ST_DIV_END].value_c, item_ff[ST_DIV_END].value_b,
                       item_ff[ST_DIV_END].value_a};

   always_comb begin
      for (int c = 0; c < COMPONENTS; c++) begin
         wr_row[c] = in_fields[c];
      end
      seg       = div_ff[ST_DIV_END].dq[DIV_W-1:FRAC_BITS];
      seg_next  = {1'b0, seg} + (TICK_W+1)'(1);
      interp    = seg_next < (TICK_W+1)'(count);
      if (count == '0) begin
         status_in = STATUS_EMPTY;
      end else if (interp) begin
         status_in = STATUS_INTERP;
      end else begin
         status_in = STATUS_HELD;
      end
      frac_in   = interp ? div_ff[ST_DIV_END].dq[FRAC_BITS-1:0] : '0;
      addr_a    = interp ? KEY_W'(seg) : KEY_W'(count - CNT_W'(1));
      addr_b    = interp ? KEY_W'(seg_next) : addr_a;
      wr_addr   = KEY_W'(item_ff[ST_DIV_END].key_index);
      wr_en     = en && valid_ff[ST_DIV_END] && (item_ff[ST_DIV_END].command == CMD_WRITE)
                  && (32'(item_ff[ST_DIV_END].key_index) < MAX_KEYS);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keyframe_mem[wr_addr] <= wr_row;
      end
      if (en) begin
         rd_a_ff <= keyframe_mem[addr_a];
         rd_b_ff <= keyframe_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mem_valid_ff <= valid_ff[ST_DIV_END] && (item_ff[ST_DIV_END].command == CMD_QUERY);
         mul_valid_ff <= mem_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mem_status_ff <= status_in;
         mem_frac_ff   <= frac_in;
         mul_status_ff <= mem_status_ff;
         mul_base_ff   <= rd_a_ff;
         for (int c = 0; c < COMPONENTS; c++) begin
            mul_prod_ff[c] <= PROD_W'((VAL_W+1)'($signed(rd_b_ff[c]))
                                      - (VAL_W+1)'($signed(rd_a_ff[c])))
                              * $signed({1'b0, mem_frac_ff});
         end
      end
   end

   always_comb begin
      logic signed [PROD_W-1:0] sum;
      res_fields = '0;
      for (int c = 0; c < COMPONENTS; c++) begin
         sum = PROD_W'($signed(mul_base_ff[c])) + (mul_prod_ff[c] >>> FRAC_BITS);
         res_fields[c] = (mul_status_ff == STATUS_EMPTY) ? '0 : sum[VAL_W-1:0];
      end
      pipe_res.result_a = res_fields[0];
      pipe_res.result_b = res_fields[1];
      pipe_res.result_c = res_fields[2];
      pipe_res.result_d = res_fields[3];
      pipe_res.result_e = res_fields[4];
      pipe_res.status   = mul_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid     <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_ready || !rsp_valid) begin
         if (skid_valid_ff) begin
            rsp_valid     <= 1'b1;
            rsp_payload   <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid     <= mul_valid_ff;
            rsp_payload   <= pipe_res;
         end
      end else if (mul_valid_ff && !skid_valid_ff) begin
         skid_ff       <= pipe_res;
         skid_valid_ff <= 1'b1;
      end
   end

endmodule

FILE: hdl/kfli_checker.sv
module kfli_checker import kfli_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result item changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status == STATUS_INTERP || rsp_payload.status == STATUS_HELD
                    || rsp_payload.status == STATUS_EMPTY)
      else $error("Result item carries an undefined status.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_EMPTY |->
         rsp_payload.result_a == '0 && rsp_payload.result_b == '0
         && rsp_payload.result_c == '0 && rsp_payload.result_d == '0
         && rsp_payload.result_e == '0)
      else $error("Empty table result item is not all zeros.");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("Input stalled while no result item is waiting.");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid after reset.");

endmodule

bind keyframe_linear_interpolator_unit kfli_checker u_checker (.*);

FILE: tb/sv/keyframe_linear_interpolator_unit_checker.sv
`timescale 1ns / 1ps

module keyframe_linear_interpolator_unit_checker import kfli_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    pending_count,
   output int                    failure_count
);

   logic signed [VAL_W-1:0] key_table [MAX_KEYS][COMPONENTS];
   logic [STEP_W-1:0]       step_length;
   logic [KEYCNT_W-1:0]     keys_in_use;
   rsp_type                 expected_samples [$];

   function automatic logic signed [VAL_W-1:0] blend(input logic signed [VAL_W-1:0] v0,
                                                     input logic signed [VAL_W-1:0] v1,
                                                     input longint frac);
      longint delta;
      longint scaled;
      delta  = longint'(v1) - longint'(v0);
      scaled = (delta * frac) >>> FRAC_BITS;
      return VAL_W'(longint'(v0) + scaled);
   endfunction

   function automatic rsp_type sample_track(input req_type r);
      rsp_type                 s;
      longint                  steps;
      longint                  count;
      longint                  seg;
      longint                  rem;
      longint                  frac;
      logic signed [VAL_W-1:0] comp [COMPONENTS];
      steps = (step_length == 0) ? 1 : longint'(step_length);
      count = (keys_in_use > MAX_KEYS) ? MAX_KEYS : longint'(keys_in_use);
      seg   = longint'(r.tick) / steps;
      rem   = longint'(r.tick) % steps;
      for (int c = 0; c < COMPONENTS; c++) comp[c] = '0;
      if (count == 0) begin
         s.status = STATUS_EMPTY;
      end else if (seg + 1 < count) begin
         frac = (rem << FRAC_BITS) / steps;
         for (int c = 0; c < COMPONENTS; c++) begin
            comp[c] = blend(key_table[seg][c], key_table[seg + 1][c], frac);
         end
         s.status = STATUS_INTERP;
      end else begin
         for (int c = 0; c < COMPONENTS; c++) comp[c] = key_table[count - 1][c];
         s.status = STATUS_HELD;
      end
      s.result_a = comp[0];
      s.result_b = comp[1];
      s.result_c = comp[2];
      s.result_d = comp[3];
      s.result_e = comp[4];
      return s;
   endfunction

   task automatic compare_field(input string name, input logic [VAL_W-1:0] want,
                                input logic [VAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         failure_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         step_length   = 1;
         keys_in_use   = 0;
         failure_count = 0;
         expected_samples.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_STEP_TICKS) step_length = csr_write_data[STEP_W-1:0];
            else if (csr_index == CSR_KEY_COUNT) keys_in_use = csr_write_data[KEYCNT_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $realtime,
                        rsp_payload);
               failure_count++;
            end else begin
               want = expected_samples.pop_front();
               compare_field("result_a", want.result_a, rsp_payload.result_a);
               compare_field("result_b", want.result_b, rsp_payload.result_b);
               compare_field("result_c", want.result_c, rsp_payload.result_c);
               compare_field("result_d", want.result_d, rsp_payload.result_d);
               compare_field("result_e", want.result_e, rsp_payload.result_e);
               compare_field("status", VAL_W'(want.status), VAL_W'(rsp_payload.status));
            end
         end
         if (req_valid && req_ready) begin
            if (req_payload.command == CMD_WRITE) begin
               key_table[req_payload.key_index][0] = req_payload.value_a;
               key_table[req_payload.key_index][1] = req_payload.value_b;
               key_table[req_payload.key_index][2] = req_payload.value_c;
               key_table[req_payload.key_index][3] = req_payload.value_d;
               key_table[req_payload.key_index][4] = req_payload.value_e;
            end else begin
               expected_samples.insert(expected_samples.size(), sample_track(req_payload));
            end
         end
      end
      pending_count = expected_samples.size();
   end

endmodule

FILE: tb/sv/keyframe_linear_interpolator_unit_tb.sv
`timescale 1ns / 1ps

module keyframe_linear_interpolator_unit_tb import kfli_pkg::*;;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    pending_count;
   int                    failure_count;
   int                    send_idle_pct;
   int                    stall_pct;
   logic                  hold_request;
   int                    cur_step;
   int                    cur_count;

   keyframe_linear_interpolator_unit dut (.*);

   keyframe_linear_interpolator_unit_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int held;
      rsp_ready = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_request && held == 0) held = 300;
         if (held > 0) begin
            held--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(2000)) - 1000) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_write(input logic [KEYIDX_W-1:0] slot);
      req_type r;
      r.command   = CMD_WRITE;
      r.key_index = slot;
      r.tick      = TICK_W'($urandom);
      r.value_a   = rand_value();
      r.value_b   = rand_value();
      r.value_c   = rand_value();
      r.value_d   = rand_value();
      r.value_e   = rand_value();
      return r;
   endfunction

   function automatic req_type make_query(input logic [TICK_W-1:0] t);
      req_type r;
      r         = make_write(KEYIDX_W'($urandom));
      r.command = CMD_QUERY;
      r.tick    = t;
      return r;
   endfunction

   function automatic logic [TICK_W-1:0] pick_tick();
      longint steps;
      longint t;
      steps = (cur_step == 0) ? 1 : cur_step;
      if ($urandom_range(3) == 0) return TICK_W'($urandom);
      t = longint'($urandom_range(cur_count > 64 ? 64 : cur_count)) * steps
          + longint'($urandom) % steps;
      return (t > 24'hff_ffff) ? 24'hff_ffff : TICK_W'(t);
   endfunction

   task automatic send_item(input req_type r);
      if (req_valid && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      if (req_valid) begin
         req_valid <= 0;
         @(posedge clock);
      end
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_config(input int step_val, input int count_val);
      cur_step = step_val;
      cur_count = count_val;
      csr_write_enable <= 1;
      csr_index        <= CSR_STEP_TICKS;
      csr_write_data   <= CSR_DATA_W'(step_val);
      @(posedge clock);
      csr_index        <= CSR_KEY_COUNT;
      csr_write_data   <= CSR_DATA_W'(count_val);
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int step_val, input int count_val, input int idle_val,
                               input int stall_val, input int items);
      req_type r;
      set_config(step_val, count_val);
      send_idle_pct = idle_val;
      stall_pct     = stall_val;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(4) == 0) r = make_write(KEYIDX_W'($urandom));
         else r = make_query(pick_tick());
         send_item(r);
      end
      drain();
   endtask

   initial begin
      req_type r;
      reset            = 1;
      req_valid        = 0;
      req_payload      = '0;
      csr_write_enable = 0;
      csr_index        = '0;
      csr_write_data   = '0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_request     = 0;
      cur_step         = 1;
      cur_count        = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(make_query(24'h00_0000));
      send_item(make_query(24'hff_ffff));
      for (int s = 0; s < MAX_KEYS; s++) begin
         r = make_write(KEYIDX_W'(s));
         if (s == 0) begin
            r.value_a = 32'h8000_0000; r.value_b = 32'h7fff_ffff; r.value_c = 0;
            r.value_d = 32'hffff_ffff; r.value_e = 32'h0001_0000;
         end else if (s == 1) begin
            r.value_a = 32'h7fff_ffff; r.value_b = 32'h8000_0000; r.value_c = 32'hffff_ffff;
            r.value_d = 0; r.value_e = 32'hfffe_0000;
         end
         send_item(r);
      end
      drain();
      set_config(65535, 64);
      send_item(make_query(24'd0));
      send_item(make_query(24'd1));
      send_item(make_query(24'd32768));
      send_item(make_query(24'd65534));
      send_item(make_query(24'd65535));
      send_item(make_query(24'hff_ffff));
      drain();
      set_config(0, 127);
      send_item(make_query(24'd0));
      send_item(make_query(24'd62));
      send_item(make_query(24'd63));
      send_item(make_query(24'hff_ffff));
      drain();
      set_config(3, 1);
      send_item(make_query(24'd0));
      send_item(make_query(24'd2));
      drain();

      random_phase(4, 64, 0, 0, 150);
      random_phase(1, 64, 74, 0, 140);
      random_phase(0, 127, 0, 74, 140);
      random_phase(65535, 2, 29, 29, 140);
      random_phase(0, 0, 0, 0, 60);
      random_phase(3, 1, 74, 74, 80);
      random_phase($urandom_range(1, 40), $urandom_range(2, 64), 29, 29, 150);
      hold_request = 1;
      repeat (2) @(posedge clock);
      hold_request = 0;
      random_phase(7, 64, 0, 0, 150);
      random_phase(65535, 64, 0, 29, 120);

      if (failure_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
